>>> design/assert_macros.svh
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, disabled while reset is high.
`define TLPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property that also holds during reset.
`define TLPQ_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLPQ_ASSERT(label, clk, rst, prop, msg)
`define TLPQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> design/tlpq_pkg.sv
package tlpq_pkg;

  // Fixed field widths and ring geometry.
  localparam int WORD_W         = 32;
  localparam int PRIO_W         = 2;
  localparam int LEVELS         = 3;
  localparam int LVL_W          = $clog2(LEVELS);
  localparam int RING_DEPTH_DEF = 16;

  // Operation codes.
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // Priority request codes; any other code selects the top level.
  localparam logic [PRIO_W-1:0] PRIO_1 = 2'd1;
  localparam logic [PRIO_W-1:0] PRIO_2 = 2'd2;

  // Ring indexes, lowest level first.
  localparam logic [LVL_W-1:0] LVL_LOW  = 2'd0;
  localparam logic [LVL_W-1:0] LVL_MID  = 2'd1;
  localparam logic [LVL_W-1:0] LVL_HIGH = 2'd2;

  // Word returned when no word is dequeued.
  localparam logic [WORD_W-1:0] WORD_NONE = '1;

  // Command queue between the front and back parts.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Control part of one command handed from front to back.
  typedef struct packed {
    logic we;
    logic re;
    logic accepted;
    logic all_empty;
  } cmd_ctl_t;

endpackage

>>> design/tlpq_ram.sv
module tlpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single port, one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/tlpq_front.sv
`include "assert_macros.svh"

module tlpq_front #(
  parameter int RING_DEPTH = tlpq_pkg::RING_DEPTH_DEF,
  parameter int ADDR_W     = $clog2(tlpq_pkg::LEVELS * RING_DEPTH)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic                             func,
  input  logic signed [tlpq_pkg::WORD_W-1:0] value,
  input  logic [tlpq_pkg::PRIO_W-1:0]      priority_req,
  input  logic                             q_full,
  output logic                             push,
  output tlpq_pkg::cmd_ctl_t               push_ctl,
  output logic [ADDR_W-1:0]                push_addr,
  output logic [tlpq_pkg::WORD_W-1:0]      push_wdata
);

  import tlpq_pkg::*;

  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [PTR_W-1:0] head      [LEVELS];
  logic [PTR_W-1:0] head_next [LEVELS];
  logic [CNT_W-1:0] fill      [LEVELS];
  logic [CNT_W-1:0] fill_next [LEVELS];

  logic [LVL_W-1:0]  lvl;
  logic [PTR_W-1:0]  sel_head;
  logic [CNT_W-1:0]  sel_fill;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail_pos;
  logic [PTR_W-1:0]  head_inc;
  logic [PTR_W-1:0]  pos;
  logic [ADDR_W-1:0] base;
  logic              any_held;
  logic              is_enq;
  logic              op_ok;
  logic              take;

  // The front takes a transaction whenever the command queue has room.
  assign req_stall = q_full;
  assign take      = req_valid && !q_full;
  assign is_enq    = (func == FUNC_ENQ);
  assign any_held  = (fill[LVL_HIGH] != '0) || (fill[LVL_MID] != '0) || (fill[LVL_LOW] != '0);

  // Pick the ring: by priority code on enqueue, highest non-empty on dequeue.
  always_comb begin
    if (is_enq) begin
      case (priority_req)
        PRIO_1:  lvl = LVL_LOW;
        PRIO_2:  lvl = LVL_MID;
        default: lvl = LVL_HIGH;
      endcase
    end else if (fill[LVL_HIGH] != '0) begin
      lvl = LVL_HIGH;
    end else if (fill[LVL_MID] != '0) begin
      lvl = LVL_MID;
    end else begin
      lvl = LVL_LOW;
    end
  end

  assign sel_head = head[lvl];
  assign sel_fill = fill[lvl];
  assign op_ok    = is_enq ? (sel_fill != CNT_W'(RING_DEPTH)) : any_held;

  // Tail position wraps with one compare and subtract.
  assign tail_sum = SUM_W'(sel_head) + SUM_W'(sel_fill);
  assign tail_pos = (tail_sum >= SUM_W'(RING_DEPTH)) ?
                    PTR_W'(tail_sum - SUM_W'(RING_DEPTH)) : PTR_W'(tail_sum);
  assign head_inc = (sel_head == PTR_W'(RING_DEPTH - 1)) ? '0 : sel_head + 1'b1;
  assign pos      = is_enq ? tail_pos : sel_head;

  // Each ring occupies its own block of the shared memory.
  always_comb begin
    case (lvl)
      LVL_MID:  base = ADDR_W'(RING_DEPTH);
      LVL_HIGH: base = ADDR_W'(2 * RING_DEPTH);
      default:  base = '0;
    endcase
  end

  // Pointer and count bookkeeping for the chosen ring.
  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      head_next[i] = head[i];
      fill_next[i] = fill[i];
    end
    if (take && op_ok) begin
      if (is_enq) begin
        fill_next[lvl] = sel_fill + 1'b1;
      end else begin
        fill_next[lvl] = sel_fill - 1'b1;
        head_next[lvl] = head_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= head_next[i];
        fill[i] <= fill_next[i];
      end
    end
  end

  // Command for the back part.
  assign push               = take;
  assign push_ctl.we        = is_enq && op_ok;
  assign push_ctl.re        = !is_enq && op_ok;
  assign push_ctl.accepted  = op_ok;
  assign push_ctl.all_empty = (fill_next[LVL_LOW] == '0) && (fill_next[LVL_MID] == '0) &&
                              (fill_next[LVL_HIGH] == '0);
  assign push_addr          = base + ADDR_W'(pos);
  assign push_wdata         = value;

  `TLPQ_ASSERT(a_fill_bound, clk, rst, (fill[LVL_LOW] <= CNT_W'(RING_DEPTH)) && (fill[LVL_MID] <= CNT_W'(RING_DEPTH)) && (fill[LVL_HIGH] <= CNT_W'(RING_DEPTH)), "ring fill count above depth")
  `TLPQ_ASSERT(a_empty_flag, clk, rst, (push && push_ctl.all_empty) |=> !any_held, "all_empty reported while a ring holds words")

endmodule

>>> design/tlpq_queue.sv
`include "assert_macros.svh"

module tlpq_queue #(
  parameter int ADDR_W = $clog2(tlpq_pkg::LEVELS * tlpq_pkg::RING_DEPTH_DEF)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  tlpq_pkg::cmd_ctl_t          push_ctl,
  input  logic [ADDR_W-1:0]           push_addr,
  input  logic [tlpq_pkg::WORD_W-1:0] push_wdata,
  output logic                        full,
  input  logic                        pop,
  output logic                        q_valid,
  output tlpq_pkg::cmd_ctl_t          q_ctl,
  output logic [ADDR_W-1:0]           q_addr,
  output logic [tlpq_pkg::WORD_W-1:0] q_wdata
);

  import tlpq_pkg::*;

  cmd_ctl_t            slot_ctl   [Q_DEPTH];
  logic [ADDR_W-1:0]   slot_addr  [Q_DEPTH];
  logic [WORD_W-1:0]   slot_wdata [Q_DEPTH];
  logic [Q_PTR_W-1:0]  wr_ptr;
  logic [Q_PTR_W-1:0]  rd_ptr;
  logic [Q_CNT_W-1:0]  count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == Q_CNT_W'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  assign q_ctl   = slot_ctl[rd_ptr];
  assign q_addr  = slot_addr[rd_ptr];
  assign q_wdata = slot_wdata[rd_ptr];

  // Command storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_ctl[wr_ptr]   <= push_ctl;
      slot_addr[wr_ptr]  <= push_addr;
      slot_wdata[wr_ptr] <= push_wdata;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TLPQ_ASSERT(a_q_bound, clk, rst, count <= Q_CNT_W'(Q_DEPTH), "command queue over capacity")

endmodule

>>> design/tlpq_back.sv
`include "assert_macros.svh"

module tlpq_back #(
  parameter int ADDR_W = $clog2(tlpq_pkg::LEVELS * tlpq_pkg::RING_DEPTH_DEF)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               q_valid,
  input  tlpq_pkg::cmd_ctl_t                 q_ctl,
  input  logic [ADDR_W-1:0]                  q_addr,
  input  logic [tlpq_pkg::WORD_W-1:0]        q_wdata,
  output logic                               pop,
  output logic                               ram_we,
  output logic                               ram_re,
  output logic [ADDR_W-1:0]                  ram_addr,
  output logic [tlpq_pkg::WORD_W-1:0]        ram_wdata,
  input  logic [tlpq_pkg::WORD_W-1:0]        ram_rdata,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               accepted,
  output logic signed [tlpq_pkg::WORD_W-1:0] data_out,
  output logic                               all_empty
);

  import tlpq_pkg::*;

  logic     st_valid;
  cmd_ctl_t st_ctl;
  logic     advance;
  logic     issue;

  // The result stage moves when it is empty or its transaction is taken.
  assign advance = !st_valid || !rsp_stall;
  assign issue   = q_valid && advance;
  assign pop     = issue;

  // Memory access for the command at the head of the queue.
  assign ram_we    = issue && q_ctl.we;
  assign ram_re    = issue && q_ctl.re;
  assign ram_addr  = q_addr;
  assign ram_wdata = q_wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (advance) begin
      st_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      st_ctl <= q_ctl;
    end
  end

  // Read data holds in the memory's output register until the next read is issued.
  assign rsp_valid = st_valid;
  assign accepted  = st_ctl.accepted;
  assign all_empty = st_ctl.all_empty;
  assign data_out  = st_ctl.re ? ram_rdata : WORD_NONE;

  `TLPQ_ASSERT(a_ram_gated, clk, rst, (ram_we || ram_re) |-> advance, "memory accessed while result stage stalled")
  `TLPQ_ASSERT(a_read_accepted, clk, rst, (st_valid && st_ctl.re) |-> st_ctl.accepted, "read result not marked accepted")
  `TLPQ_ASSERT(a_one_op, clk, rst, q_valid |-> !(q_ctl.we && q_ctl.re), "command both writes and reads")

endmodule

>>> design/three_level_priority_queue_unit.sv
// Channel   Handshake             Payload
// request   req_valid/req_stall   func, value, priority_req
// response  rsp_valid/rsp_stall   accepted, data_out, all_empty
//
// One transaction enters per cycle while the command queue has room; its response passes
// through the two-entry command queue and the registered read of the ring memory.
// Reset (rst, synchronous) empties all rings and the command queue; no clearing pass.
// A stalled response holds the back part; requests continue until the queue fills.
module three_level_priority_queue_unit #(
  parameter int RING_DEPTH = tlpq_pkg::RING_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               func,
  input  logic signed [tlpq_pkg::WORD_W-1:0] value,
  input  logic [tlpq_pkg::PRIO_W-1:0]        priority_req,
  output logic                               rsp_valid,
  input  logic                               rsp_stall,
  output logic                               accepted,
  output logic signed [tlpq_pkg::WORD_W-1:0] data_out,
  output logic                               all_empty
);

  import tlpq_pkg::*;

  localparam int MEM_DEPTH = LEVELS * RING_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  logic              q_full;
  logic              push;
  cmd_ctl_t          push_ctl;
  logic [ADDR_W-1:0] push_addr;
  logic [WORD_W-1:0] push_wdata;
  logic              pop;
  logic              q_valid;
  cmd_ctl_t          q_ctl;
  logic [ADDR_W-1:0] q_addr;
  logic [WORD_W-1:0] q_wdata;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // Front part: ring selection and pointer bookkeeping.
  tlpq_front #(
    .RING_DEPTH (RING_DEPTH),
    .ADDR_W     (ADDR_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .value        (value),
    .priority_req (priority_req),
    .q_full       (q_full),
    .push         (push),
    .push_ctl     (push_ctl),
    .push_addr    (push_addr),
    .push_wdata   (push_wdata)
  );

  // Command queue between the two parts.
  tlpq_queue #(
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ctl   (push_ctl),
    .push_addr  (push_addr),
    .push_wdata (push_wdata),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_ctl      (q_ctl),
    .q_addr     (q_addr),
    .q_wdata    (q_wdata)
  );

  // Back part: memory access and result register.
  tlpq_back #(
    .ADDR_W (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ctl     (q_ctl),
    .q_addr    (q_addr),
    .q_wdata   (q_wdata),
    .pop       (pop),
    .ram_we    (ram_we),
    .ram_re    (ram_re),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .accepted  (accepted),
    .data_out  (data_out),
    .all_empty (all_empty)
  );

  // Ring storage for all three levels.
  tlpq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import tlpq_pkg::*;

  // Priority codes that the package does not name; both select the top level.
  localparam logic [PRIO_W-1:0] PRIO_ZERO = 2'd0;
  localparam logic [PRIO_W-1:0] PRIO_TOP  = 2'd3;

  localparam int DEPTH          = RING_DEPTH_DEF;
  localparam int GAP_MAX        = 17;
  localparam int HOLD_CYCLES    = 60;
  localparam int HOLD_AT_RSP    = 300;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 50;
  localparam int RANDOM_PHASES  = 20;
  localparam int REPORT_LIMIT   = 10;

  // One response transaction.
  typedef struct packed {
    logic              acc;
    logic [WORD_W-1:0] data;
    logic              empty;
  } qresult_t;

  // One row of the directed stimulus.
  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] word;
    logic [PRIO_W-1:0] prio;
    logic [5:0]        rep;
    logic              rnd_word;
    logic              typed;
    qresult_t          res;
  } dir_row_t;

  localparam int N_ROWS = 13;

  // Rows with a typed result are checked against it; the others use the predictor.
  localparam dir_row_t DIR_ROWS [N_ROWS] = '{
    // Dequeue right after reset finds every ring empty.
    '{FUNC_DEQ, 32'h0000_0000, PRIO_ZERO, 6'd1, 1'b0, 1'b1, '{1'b0, WORD_NONE, 1'b1}},
    // Extreme words into each level, code zero included.
    '{FUNC_ENQ, 32'h7fff_ffff, PRIO_1, 6'd1, 1'b0, 1'b1, '{1'b1, WORD_NONE, 1'b0}},
    '{FUNC_ENQ, 32'h8000_0000, PRIO_2, 6'd1, 1'b0, 1'b1, '{1'b1, WORD_NONE, 1'b0}},
    '{FUNC_ENQ, 32'hffff_ffff, PRIO_TOP, 6'd1, 1'b0, 1'b1, '{1'b1, WORD_NONE, 1'b0}},
    '{FUNC_ENQ, 32'h0000_0000, PRIO_ZERO, 6'd1, 1'b0, 1'b1, '{1'b1, WORD_NONE, 1'b0}},
    // Drain in strict priority order; the first word out equals all ones.
    '{FUNC_DEQ, 32'hffff_ffff, PRIO_TOP, 6'd1, 1'b0, 1'b1, '{1'b1, 32'hffff_ffff, 1'b0}},
    '{FUNC_DEQ, 32'h0000_0000, PRIO_1, 6'd1, 1'b0, 1'b1, '{1'b1, 32'h0000_0000, 1'b0}},
    '{FUNC_DEQ, 32'h0000_0000, PRIO_2, 6'd1, 1'b0, 1'b1, '{1'b1, 32'h8000_0000, 1'b0}},
    '{FUNC_DEQ, 32'h0000_0000, PRIO_ZERO, 6'd1, 1'b0, 1'b1, '{1'b1, 32'h7fff_ffff, 1'b1}},
    '{FUNC_DEQ, 32'h0000_0000, PRIO_ZERO, 6'd1, 1'b0, 1'b1, '{1'b0, WORD_NONE, 1'b1}},
    // Fill the middle ring, then try one more.
    '{FUNC_ENQ, 32'h0000_0000, PRIO_2, DEPTH[5:0], 1'b1, 1'b0, '0},
    '{FUNC_ENQ, 32'h1234_5678, PRIO_2, 6'd1, 1'b0, 1'b1, '{1'b0, WORD_NONE, 1'b0}},
    '{FUNC_DEQ, 32'h0000_0000, PRIO_ZERO, 6'd1, 1'b0, 1'b0, '0}
  };

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     req_valid = 1'b0;
  logic                     req_stall;
  logic                     func = FUNC_ENQ;
  logic signed [WORD_W-1:0] value = '0;
  logic [PRIO_W-1:0]        priority_req = PRIO_1;
  logic                     rsp_valid;
  logic                     rsp_stall = 1'b0;
  logic                     accepted;
  logic signed [WORD_W-1:0] data_out;
  logic                     all_empty;

  // Typed expectation that travels with the current request.
  logic     row_typed = 1'b0;
  qresult_t row_result = '0;

  // Predictor state: ring contents, heads and fill levels per level.
  logic [WORD_W-1:0] ring_words [LEVELS][DEPTH];
  int unsigned       ring_head [LEVELS];
  int unsigned       ring_fill [LEVELS];

  qresult_t pending_results [$];
  int       failures = 0;
  int       mismatches = 0;
  int       idle_cycles = 0;

  three_level_priority_queue_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .func         (func),
    .value        (value),
    .priority_req (priority_req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .accepted     (accepted),
    .data_out     (data_out),
    .all_empty    (all_empty)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Applies one request transaction to the predicted queue state.
  function automatic qresult_t queue_step(input logic op, input logic [WORD_W-1:0] word,
                                          input logic [PRIO_W-1:0] prio);
    qresult_t r;
    int       lvl;
    r.acc  = 1'b0;
    r.data = WORD_NONE;
    if (op == FUNC_ENQ) begin
      lvl = (prio == PRIO_1) ? LVL_LOW : (prio == PRIO_2) ? LVL_MID : LVL_HIGH;
      if (ring_fill[lvl] < DEPTH) begin
        ring_words[lvl][(ring_head[lvl] + ring_fill[lvl]) % DEPTH] = word;
        ring_fill[lvl]++;
        r.acc = 1'b1;
      end
    end else begin
      for (lvl = LEVELS - 1; lvl >= 0 && !r.acc; lvl--) begin
        if (ring_fill[lvl] != 0) begin
          r.data = ring_words[lvl][ring_head[lvl]];
          ring_head[lvl] = (ring_head[lvl] + 1) % DEPTH;
          ring_fill[lvl]--;
          r.acc = 1'b1;
        end
      end
    end
    r.empty = (ring_fill[LVL_LOW] == 0) && (ring_fill[LVL_MID] == 0) &&
              (ring_fill[LVL_HIGH] == 0);
    return r;
  endfunction

  // Monitor: checks responses, predicts requests and watches for a hang.
  always @(posedge clk) begin
    qresult_t exp_r;
    qresult_t got_r;
    qresult_t pred_r;
    if (rst) begin
      for (int l = 0; l < LEVELS; l++) begin
        ring_head[l] = 0;
        ring_fill[l] = 0;
      end
    end else begin
      // The response is matched first, so it never pairs with a request of this edge.
      if (rsp_valid && !rsp_stall) begin
        got_r = '{accepted, data_out, all_empty};
        if (pending_results.size() == 0) begin
          failures++;
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected response: accepted %0b data_out %h all_empty %0b",
                     accepted, data_out, all_empty);
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r !== exp_r) begin
            failures++;
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("mismatch: accepted %0b/%0b data_out %h/%h all_empty %0b/%0b",
                       exp_r.acc, accepted, exp_r.data, data_out, exp_r.empty, all_empty);
          end
        end
      end
      if (req_valid && !req_stall) begin
        pred_r = queue_step(func, value, priority_req);
        pending_results.push_back(row_typed ? row_result : pred_r);
      end
    end
    // Any accepted transaction on either channel counts as progress.
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Offers one request transaction after a gap and waits until it is taken.
  task automatic send_request(input logic op, input logic [WORD_W-1:0] word,
                              input logic [PRIO_W-1:0] prio, input logic typed,
                              input qresult_t res, input int gap);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid    <= 1'b1;
    func         <= op;
    value        <= word;
    priority_req <= prio;
    row_typed    <= typed;
    row_result   <= res;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  // Sender: reset, directed rows, then phases of random traffic.
  initial begin
    int          i;
    int          k;
    int          ph;
    int          enq_pct;
    bit          gaps_on;
    bit          focus;
    logic [PRIO_W-1:0] focus_prio;
    logic [PRIO_W-1:0] prio;
    logic [WORD_W-1:0] word;
    logic              op;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < N_ROWS; i++) begin
      for (k = 0; k < DIR_ROWS[i].rep; k++) begin
        word = DIR_ROWS[i].rnd_word ? $urandom : DIR_ROWS[i].word;
        send_request(DIR_ROWS[i].op, word, DIR_ROWS[i].prio, DIR_ROWS[i].typed,
                     DIR_ROWS[i].res, $urandom_range(0, GAP_MAX));
      end
    end

    // Let everything come back before the random part; the monitor books the
    // last request at its accepting edge, so look only from the next edge on.
    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      // Each phase picks an enqueue share from 25 to 90 percent, sometimes on one level only.
      case ($urandom_range(0, 3))
        0: enq_pct = 25;
        1: enq_pct = 50;
        2: enq_pct = 75;
        default: enq_pct = 90;
      endcase
      gaps_on    = ($urandom_range(0, 2) != 0);
      focus      = ($urandom_range(0, 3) == 0);
      focus_prio = PRIO_W'($urandom_range(0, 3));
      // Halfway through, pause until every response is back.
      if (ph == RANDOM_PHASES / 2) begin
        req_valid <= 1'b0;
        do begin
          @(posedge clk);
        end while (pending_results.size() != 0);
      end
      for (k = 0; k < PHASE_ITEMS; k++) begin
        op   = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
        prio = focus ? focus_prio : PRIO_W'($urandom_range(0, 3));
        case ($urandom_range(0, 15))
          0: word = 32'h0000_0000;
          1: word = 32'hffff_ffff;
          2: word = 32'h7fff_ffff;
          3: word = 32'h8000_0000;
          default: word = $urandom;
        endcase
        send_request(op, word, prio, 1'b0, '0, gaps_on ? $urandom_range(0, GAP_MAX) : 0);
      end
    end

    req_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

  // Receiver: random stall before each response, one long hold-off, calm stretches.
  initial begin
    int n;
    int rsp_seen;
    rsp_seen = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rsp_seen == HOLD_AT_RSP) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = (((rsp_seen / 100) % 4) == 2) ? 0 : $urandom_range(0, GAP_MAX);
      if (n > 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      @(posedge clk);
      while (!(rsp_valid && !rsp_stall)) @(posedge clk);
      rsp_seen++;
    end
  end

endmodule

>>> three_level_priority_queue_unit.f
+incdir+design
design/tlpq_pkg.sv
design/tlpq_ram.sv
design/tlpq_front.sv
design/tlpq_queue.sv
design/tlpq_back.sv
design/three_level_priority_queue_unit.sv
test/testbench.sv
